// ===== design/gudc_pkg.sv =====
// Package for the greedy unit-disk cover block.
// Holds widths, register indices, the controller state type and the disk job record.
// No dependencies.
package gudc_pkg;

    localparam int COORD_BITS      = 14;
    localparam int MAX_CENTERS_DEF = 256;
    localparam int SEP_W           = 30;
    localparam int OFF_W           = 8;
    localparam int DISK_X_W        = 15;
    localparam int DISK_Y_W        = 16;
    localparam int SLOT_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT    = 2'd2;

    localparam logic [SEP_W-1:0] MIN_SEP_RST = 30'd400;
    localparam logic [OFF_W-1:0] HORIZ_RST   = 8'd8;
    localparam logic [OFF_W-1:0] VERT_RST    = 8'd15;

    localparam logic [SLOT_W-1:0] SLOT_POINT = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LOWER = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_UPPER = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_FAR   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } scan_state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [OFF_W-1:0]      h;
        logic [OFF_W-1:0]      v;
        logic                  full;
    } disk_job_t;

endpackage

// ===== design/gudc_if.sv =====
// Handshake channel interfaces for points in and disk centres out.
// Depends on gudc_pkg.
interface point_if
    import gudc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  first_point;

    modport source (output valid, output point_x, output point_y, output first_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input first_point,
                    output ready);
endinterface

interface disk_if
    import gudc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [DISK_X_W-1:0]        disk_x;
    logic signed [DISK_Y_W-1:0] disk_y;
    logic [SLOT_W-1:0]          disk_slot;
    logic                       last_disk;
    logic                       store_full;

    modport source (output valid, output disk_x, output disk_y, output disk_slot,
                    output last_disk, output store_full, input ready);
    modport sink   (input valid, input disk_x, input disk_y, input disk_slot,
                    input last_disk, input store_full, output ready);
endinterface

// ===== design/greedy_unit_disk_cover_unit.sv =====
// Greedy unit-disk cover: top level with the scan controller and distance pipeline.
// A point is checked against N stored centres read one per cycle from the store; the
// next point is taken once the scan, drain and decide states are through (straight to
// decide when the set is empty or cleared), and later while the emitter still holds
// the previous point's four disks. The first disk can transfer once decide has handed
// the job to the emitter; the other three follow one per cycle while ready is held high.
// Reset empties the set and loads the register defaults; the store itself is not cleared.
module greedy_unit_disk_cover_unit
    import gudc_pkg::*;
#(
    parameter int MAX_CENTERS = MAX_CENTERS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    point_if.sink                 point,
    disk_if.source                disk,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_CENTERS);
    localparam int CW = $clog2(MAX_CENTERS + 1);
    localparam int SQ_W = 2 * COORD_BITS;

    scan_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic hit_reg, hit_next;
    logic rd_vld_reg, sq_vld_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;

    logic [SEP_W-1:0] min_sep_reg;
    logic [OFF_W-1:0] horiz_reg, vert_reg;

    logic rd_en;
    logic wr_en;
    logic [2*COORD_BITS-1:0] rd_data;
    logic signed [COORD_BITS:0] dx, dy;
    logic signed [2*COORD_BITS+1:0] prod_x, prod_y;
    logic [SQ_W:0] dist_sq;
    logic too_close;
    logic full;
    logic job_valid, job_ready;
    disk_job_t job;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sep_reg <= MIN_SEP_RST;
            horiz_reg   <= HORIZ_RST;
            vert_reg    <= VERT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MIN_SEP: min_sep_reg <= cfg_data[SEP_W-1:0];
                CFG_HORIZ:   horiz_reg   <= cfg_data[OFF_W-1:0];
                CFG_VERT:    vert_reg    <= cfg_data[OFF_W-1:0];
                default:     ;
            endcase
        end
    end

    gudc_center_mem #(
        .DEPTH (MAX_CENTERS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({px_reg, py_reg}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Distance pipeline: read data, squares, then the threshold compare.
    always_comb
    begin
        dx = $signed({1'b0, px_reg}) - $signed({1'b0, rd_data[2*COORD_BITS-1:COORD_BITS]});
        dy = $signed({1'b0, py_reg}) - $signed({1'b0, rd_data[COORD_BITS-1:0]});
        prod_x = dx * dx;
        prod_y = dy * dy;
        dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        too_close = (SEP_W'(dist_sq) <= min_sep_reg);
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= prod_x[SQ_W-1:0];
        sqy_reg <= prod_y[SQ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            sq_vld_reg <= rd_vld_reg;
        end
    end

    assign full = (count_reg == CW'(MAX_CENTERS));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        point.ready = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        job_valid   = 1'b0;
        if (sq_vld_reg && too_close)
        begin
            hit_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                point.ready = 1'b1;
                if (point.valid)
                begin
                    hit_next = 1'b0;
                    idx_next = '0;
                    if (point.first_point)
                    begin
                        count_next = '0;
                    end
                    if (point.first_point || count_reg == '0)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (CW'(idx_reg) == count_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !sq_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (hit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (job_ready)
                begin
                    job_valid  = 1'b1;
                    state_next = ST_IDLE;
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point.valid && point.ready)
        begin
            px_reg <= point.point_x;
            py_reg <= point.point_y;
        end
    end

    always_comb
    begin
        job.x    = px_reg;
        job.y    = py_reg;
        job.h    = horiz_reg;
        job.v    = vert_reg;
        job.full = full;
    end

    gudc_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .disk      (disk)
    );

endmodule

// ===== design/gudc_center_mem.sv =====
// Centre store: one write port and one read port with registered read data.
// Depends on gudc_pkg.
module gudc_center_mem
    import gudc_pkg::*;
#(
    parameter int DEPTH = MAX_CENTERS_DEF
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [2*COORD_BITS-1:0]    wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [2*COORD_BITS-1:0]    rd_data
);

    logic [2*COORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/gudc_emit.sv =====
// Disk emitter: holds one accepted point and presents its four disk centres in turn.
// Depends on gudc_pkg and disk_if.
module gudc_emit
    import gudc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  disk_job_t job,
    output logic      job_ready,
    disk_if.source    disk
);

    disk_job_t         job_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [OFF_W:0]    x_off;
    logic              load;

    assign job_ready = !busy_reg;
    assign load      = job_valid && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (load)
        begin
            busy_next = 1'b1;
            slot_next = SLOT_POINT;
        end
        else if (busy_reg && disk.ready)
        begin
            if (slot_reg == SLOT_FAR)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_POINT;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
    end

    always_comb
    begin
        case (slot_reg)
            SLOT_POINT: x_off = '0;
            SLOT_LOWER: x_off = {1'b0, job_reg.h};
            SLOT_UPPER: x_off = {1'b0, job_reg.h};
            SLOT_FAR:   x_off = {job_reg.h, 1'b0};
            default:    x_off = '0;
        endcase
    end

    always_comb
    begin
        disk.valid      = busy_reg;
        disk.disk_x     = DISK_X_W'(job_reg.x) + DISK_X_W'(x_off);
        case (slot_reg)
            SLOT_LOWER: disk.disk_y = DISK_Y_W'(job_reg.y) - DISK_Y_W'(job_reg.v);
            SLOT_UPPER: disk.disk_y = DISK_Y_W'(job_reg.y) + DISK_Y_W'(job_reg.v);
            default:    disk.disk_y = DISK_Y_W'(job_reg.y);
        endcase
        disk.disk_slot  = slot_reg;
        disk.last_disk  = (slot_reg == SLOT_FAR);
        disk.store_full = job_reg.full;
    end

endmodule
